### rtl/mrrp_pkg.sv
package mrrp_pkg;

	typedef enum logic [2:0] {
		PH_ADDR    = 3'd0,
		PH_FUNC    = 3'd1,
		PH_COUNT   = 3'd2,
		PH_BODY    = 3'd3,
		PH_SKIP    = 3'd4,
		PH_DISCARD = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KIND_WORD      = 3'd0,
		KIND_BLOWER    = 3'd1,
		KIND_WRITE_ACK = 3'd2,
		KIND_READ_OK   = 3'd3,
		KIND_CRC_ERR   = 3'd4,
		KIND_BAD_ADDR  = 3'd5,
		KIND_BAD_FUNC  = 3'd6,
		KIND_TOO_LONG  = 3'd7
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  word_index;
		logic [15:0] word_value;
		logic        blower_running;
		logic        last;
	} result_t;

	localparam logic [7:0]  FC_READ      = 8'd3;
	localparam logic [7:0]  FC_WRITE     = 8'd6;
	localparam logic [8:0]  LEN_WRITE    = 9'd8;
	localparam logic [8:0]  LEN_OVERHEAD = 9'd5;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic        REG_SLAVE_ADDR = 1'b0;

	// crc-16/modbus over one byte, reflected
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/modbus_rtu_response_parser_unit.sv
// Modbus RTU response parser.
// Input channel: byte_valid/byte_ready carry one received byte per transfer,
// with frame_start forcing that byte to open a new frame.
// Output channel: result_valid/result_ready carry result items; last marks
// the final result caused by one byte.
// Configuration: APB write of slave_address at byte address 0, reset value 1.
// Every byte is parsed in the cycle it is taken (crc update, phase, counts),
// so a byte is accepted every cycle while the result register is free or
// being emptied. A result appears in the cycle after its byte is taken.
// A good read response with REG_BYTES data bytes gives REG_BYTES/2 register
// words, one per cycle unless stalled, shifted out of the data byte line; no
// bytes are taken until the last word is loaded into the result register.
// Reset clears the parse state and crc, drops any result and waits for an
// address byte. When the receiver stalls, the result register holds and no
// byte is taken until the waiting result has been transferred.
module modbus_rtu_response_parser_unit #(
	parameter int REG_BYTES = 26
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  mrrp_pkg::rx_item_t  byte_data,
	output logic                result_valid,
	input  logic                result_ready,
	output mrrp_pkg::result_t   result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int NWORDS = REG_BYTES / 2;
	localparam int WCW = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	logic [7:0]              slave_address_q;
	mrrp_pkg::phase_t        phase_q, phase_nxt;
	logic [8:0]              byte_counter_q, byte_counter_nxt;
	logic [8:0]              expected_length_q, expected_length_nxt;
	logic [7:0]              function_code_q, function_code_nxt;
	logic [15:0]             crc_q, crc_nxt;
	logic [7:0]              held_crc_q, held_crc_nxt;
	logic [7:0]              data_line_q [REG_BYTES];

	logic                    store_byte;
	logic                    emit;
	mrrp_pkg::kind_t         emit_kind;
	logic                    start_burst;
	logic                    blower_bit;

	logic                    out_valid_q;
	mrrp_pkg::result_t       out_q;
	logic                    burst_q;
	logic [WCW-1:0]          wcnt_q;

	logic                    accept;
	logic                    take;
	logic                    load_word;
	logic [7:0]              b;
	logic [9:0]              idx_plus2;
	logic [8:0]              count_val;
	logic [8:0]              skip_cnt;
	logic                    crc_ok;
	logic [15:0]             head_word;

	assign accept = byte_valid && byte_ready;
	assign take = out_valid_q && result_ready;
	assign byte_ready = !burst_q && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result = out_q;
	assign b = byte_data.rx_byte;
	assign idx_plus2 = {1'b0, byte_counter_q} + 10'd2;
	assign count_val = expected_length_q - mrrp_pkg::LEN_OVERHEAD;
	assign skip_cnt = byte_counter_q + 9'd1;
	assign crc_ok = (held_crc_q == crc_q[7:0]) && (b == crc_q[15:8]);
	assign head_word = {data_line_q[REG_BYTES-1], data_line_q[REG_BYTES-2]};
	assign blower_bit = (data_line_q[0] == 8'd1);

	// next state of the parser
	always_comb begin
		mrrp_pkg::phase_t ph;
		ph = byte_data.frame_start ? mrrp_pkg::PH_ADDR : phase_q;
		phase_nxt = ph;
		byte_counter_nxt = byte_counter_q;
		expected_length_nxt = expected_length_q;
		function_code_nxt = function_code_q;
		crc_nxt = crc_q;
		held_crc_nxt = held_crc_q;
		store_byte = 1'b0;
		case (ph)
			mrrp_pkg::PH_ADDR: begin
				crc_nxt = mrrp_pkg::crc_fold(mrrp_pkg::CRC_INIT, b);
				byte_counter_nxt = 9'd1;
				expected_length_nxt = 9'd0;
				phase_nxt = (b == slave_address_q) ? mrrp_pkg::PH_FUNC
					: mrrp_pkg::PH_DISCARD;
			end
			mrrp_pkg::PH_FUNC: begin
				crc_nxt = mrrp_pkg::crc_fold(crc_q, b);
				function_code_nxt = b;
				byte_counter_nxt = 9'd2;
				if (b == mrrp_pkg::FC_WRITE) begin
					expected_length_nxt = mrrp_pkg::LEN_WRITE;
					phase_nxt = mrrp_pkg::PH_BODY;
				end else if (b == mrrp_pkg::FC_READ) begin
					phase_nxt = mrrp_pkg::PH_COUNT;
				end else begin
					phase_nxt = mrrp_pkg::PH_DISCARD;
				end
			end
			mrrp_pkg::PH_COUNT: begin
				crc_nxt = mrrp_pkg::crc_fold(crc_q, b);
				byte_counter_nxt = 9'd3;
				expected_length_nxt = {1'b0, b} + mrrp_pkg::LEN_OVERHEAD;
				phase_nxt = ({1'b0, b} > 9'(REG_BYTES)) ? mrrp_pkg::PH_SKIP
					: mrrp_pkg::PH_BODY;
			end
			mrrp_pkg::PH_BODY: begin
				if (idx_plus2 < {1'b0, expected_length_q}) begin
					crc_nxt = mrrp_pkg::crc_fold(crc_q, b);
					store_byte = (function_code_q == mrrp_pkg::FC_READ)
						&& (byte_counter_q >= 9'd3)
						&& ((byte_counter_q - 9'd3) < 9'(REG_BYTES));
					byte_counter_nxt = byte_counter_q + 9'd1;
				end else if (idx_plus2 == {1'b0, expected_length_q}) begin
					held_crc_nxt = b;
					byte_counter_nxt = byte_counter_q + 9'd1;
				end else begin
					phase_nxt = mrrp_pkg::PH_ADDR;
					byte_counter_nxt = 9'd0;
				end
			end
			mrrp_pkg::PH_SKIP: begin
				byte_counter_nxt = skip_cnt;
				if (skip_cnt >= expected_length_q) begin
					phase_nxt = mrrp_pkg::PH_ADDR;
					byte_counter_nxt = 9'd0;
				end
			end
			default: begin
			end
		endcase
	end

	// result caused by the byte
	always_comb begin
		mrrp_pkg::phase_t ph;
		ph = byte_data.frame_start ? mrrp_pkg::PH_ADDR : phase_q;
		emit = 1'b0;
		emit_kind = mrrp_pkg::KIND_READ_OK;
		start_burst = 1'b0;
		case (ph)
			mrrp_pkg::PH_ADDR: begin
				emit = (b != slave_address_q);
				emit_kind = mrrp_pkg::KIND_BAD_ADDR;
			end
			mrrp_pkg::PH_FUNC: begin
				emit = (b != mrrp_pkg::FC_WRITE) && (b != mrrp_pkg::FC_READ);
				emit_kind = mrrp_pkg::KIND_BAD_FUNC;
			end
			mrrp_pkg::PH_BODY: begin
				if (idx_plus2 > {1'b0, expected_length_q}) begin
					emit = 1'b1;
					if (!crc_ok) begin
						emit_kind = mrrp_pkg::KIND_CRC_ERR;
					end else if (function_code_q == mrrp_pkg::FC_WRITE) begin
						emit_kind = mrrp_pkg::KIND_WRITE_ACK;
					end else if (count_val == 9'(REG_BYTES)) begin
						emit_kind = mrrp_pkg::KIND_WORD;
						start_burst = 1'b1;
					end else if (count_val == 9'd2) begin
						emit_kind = mrrp_pkg::KIND_BLOWER;
					end else begin
						emit_kind = mrrp_pkg::KIND_READ_OK;
					end
				end
			end
			mrrp_pkg::PH_SKIP: begin
				emit = (skip_cnt >= expected_length_q);
				emit_kind = mrrp_pkg::KIND_TOO_LONG;
			end
			default: begin
			end
		endcase
	end

	assign load_word = (accept && emit && start_burst) || (take && burst_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mrrp_pkg::PH_ADDR;
			byte_counter_q <= 9'd0;
			expected_length_q <= 9'd0;
			function_code_q <= 8'd0;
			crc_q <= mrrp_pkg::CRC_INIT;
			held_crc_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			byte_counter_q <= byte_counter_nxt;
			expected_length_q <= expected_length_nxt;
			function_code_q <= function_code_nxt;
			crc_q <= crc_nxt;
			held_crc_q <= held_crc_nxt;
		end
	end

	// data bytes enter at the young end; words leave two bytes at a time
	always_ff @(posedge clk) begin
		if (accept && store_byte) begin
			data_line_q[0] <= b;
			for (int i = 1; i < REG_BYTES; i++) begin
				data_line_q[i] <= data_line_q[i-1];
			end
		end else if (load_word) begin
			data_line_q[0] <= 8'd0;
			data_line_q[1] <= 8'd0;
			for (int i = 2; i < REG_BYTES; i++) begin
				data_line_q[i] <= data_line_q[i-2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			burst_q <= 1'b0;
			wcnt_q <= '0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
			burst_q <= start_burst && (NWORDS > 1);
			wcnt_q <= WCW'(1);
		end else if (take && burst_q) begin
			wcnt_q <= wcnt_q + WCW'(1);
			if (wcnt_q == WCW'(NWORDS - 1)) begin
				burst_q <= 1'b0;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_q.kind <= emit_kind;
			out_q.word_index <= 4'd0;
			out_q.word_value <= start_burst ? head_word : 16'd0;
			out_q.blower_running <= (emit_kind == mrrp_pkg::KIND_BLOWER) ? blower_bit : 1'b0;
			out_q.last <= !(start_burst && (NWORDS > 1));
		end else if (take && burst_q) begin
			out_q.kind <= mrrp_pkg::KIND_WORD;
			out_q.word_index <= 4'(wcnt_q);
			out_q.word_value <= head_word;
			out_q.blower_running <= 1'b0;
			out_q.last <= (wcnt_q == WCW'(NWORDS - 1));
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == mrrp_pkg::REG_SLAVE_ADDR) && (paddr[1:0] == 2'd0)) begin
			slave_address_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == mrrp_pkg::REG_SLAVE_ADDR) ? {24'd0, slave_address_q} : 32'd0;

	a_burst_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> (out_valid_q && (out_q.kind == mrrp_pkg::KIND_WORD) && !out_q.last))
		else $error("word burst pending without a non-final word in the result register");

	a_burst_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> (phase_q == mrrp_pkg::PH_ADDR))
		else $error("word burst while a frame is still being parsed");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(take && out_q.last) |=> !burst_q)
		else $error("word burst continues after the final word");

endmodule

### bench/tb_modbus_rtu_response_parser_unit.sv
module tb_modbus_rtu_response_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REG_BYTES = 26;

	// where a directed byte comes from
	typedef enum logic [2:0] {
		BYTE_FIXED,
		BYTE_RAND,
		BYTE_CRC_LO,
		BYTE_CRC_HI,
		BYTE_CRC_HI_BAD
	} byte_src_t;

	// what a directed byte is expected to produce
	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_NONE,
		EXP_TYPED
	} exp_src_t;

	typedef struct packed {
		logic [7:0]      data;
		logic            fs;
		logic [7:0]      rep;
		byte_src_t       src;
		exp_src_t        exp;
		mrrp_pkg::kind_t kind;
		logic            run;
	} step_row_t;

	logic                clk;
	logic                arst_n;
	logic                byte_valid;
	logic                byte_ready;
	mrrp_pkg::rx_item_t  byte_data;
	logic                result_valid;
	logic                result_ready;
	mrrp_pkg::result_t   result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// parser state as predicted
	mrrp_pkg::phase_t    ph = mrrp_pkg::PH_ADDR;
	logic [8:0]          cnt = '0;
	logic [8:0]          flen = '0;
	logic [7:0]          fcode = '0;
	logic [15:0]         crc_reg = mrrp_pkg::CRC_INIT;
	logic [7:0]          held_lo = '0;
	logic [7:0]          data_store [REG_BYTES];
	logic [7:0]          addr_cfg = 8'd1;

	mrrp_pkg::result_t   step_results [$];
	mrrp_pkg::result_t   pending_results [$];
	int                  mismatches = 0;

	exp_src_t            cur_exp = EXP_MODEL;
	mrrp_pkg::kind_t     cur_kind = mrrp_pkg::KIND_WORD;
	logic                cur_run = 1'b0;
	bit                  tx_calm = 0;
	bit                  rx_calm = 0;
	bit                  need_start = 1;
	int                  frame_items = 0;

	step_row_t plan [0:54] = '{
		// address mismatch, then a byte ignored while discarding
		'{8'h00, 1'b1, 8'd1, BYTE_FIXED, EXP_TYPED, mrrp_pkg::KIND_BAD_ADDR, 1'b0},
		'{8'hFF, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		// unknown function and exception reply
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_FIXED, EXP_TYPED, mrrp_pkg::KIND_BAD_FUNC, 1'b0},
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h83, 1'b0, 8'd1, BYTE_FIXED, EXP_TYPED, mrrp_pkg::KIND_BAD_FUNC, 1'b0},
		// write ack
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h06, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'hFF, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'hFF, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_LO, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_HI, EXP_TYPED, mrrp_pkg::KIND_WRITE_ACK, 1'b0},
		// blower running
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h03, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h02, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h01, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_LO, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_HI, EXP_TYPED, mrrp_pkg::KIND_BLOWER, 1'b1},
		// blower stopped, frame opened without a forced start
		'{8'h01, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h03, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h02, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'hFF, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'hFE, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_LO, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_HI, EXP_TYPED, mrrp_pkg::KIND_BLOWER, 1'b0},
		// empty read
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h03, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_LO, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_HI, EXP_TYPED, mrrp_pkg::KIND_READ_OK, 1'b0},
		// crc error
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h03, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_LO, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_HI_BAD, EXP_TYPED, mrrp_pkg::KIND_CRC_ERR, 1'b0},
		// register read cut short by a forced start, then a full one of all ones
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h03, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h1A, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd5, BYTE_RAND, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h03, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h1A, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'hFF, 1'b0, 8'd26, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_LO, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_CRC_HI, EXP_MODEL, mrrp_pkg::KIND_WORD, 1'b0},
		// byte count one over the store, counted out
		'{8'h01, 1'b1, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h03, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h1B, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd28, BYTE_RAND, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0},
		'{8'h00, 1'b0, 8'd1, BYTE_RAND, EXP_TYPED, mrrp_pkg::KIND_TOO_LONG, 1'b0},
		// address mismatch straight after a counted-out frame
		'{8'h00, 1'b0, 8'd1, BYTE_FIXED, EXP_TYPED, mrrp_pkg::KIND_BAD_ADDR, 1'b0},
		'{8'hFF, 1'b0, 8'd1, BYTE_FIXED, EXP_NONE, mrrp_pkg::KIND_WORD, 1'b0}
	};

	modbus_rtu_response_parser_unit #(
		.REG_BYTES(REG_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// reflected crc-16, lsb first
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc ^ {8'h00, b};
		repeat (8) begin
			fb = c[0];
			c = {1'b0, c[15:1]};
			if (fb) begin
				c = c ^ 16'hA001;
			end
		end
		return c;
	endfunction

	function automatic void add_result(input mrrp_pkg::kind_t k, input int w,
			input logic [15:0] v, input logic run);
		mrrp_pkg::result_t r;
		r.kind = k;
		r.word_index = 4'(w);
		r.word_value = v;
		r.blower_running = run;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	// advance the predicted parser by one byte, results into step_results
	task automatic parse_byte(input mrrp_pkg::rx_item_t it);
		logic [7:0]        b;
		int                idx;
		int                dcount;
		mrrp_pkg::result_t r;
		b = it.rx_byte;
		step_results = {};
		if (it.frame_start) begin
			ph = mrrp_pkg::PH_ADDR;
		end
		case (ph)
			mrrp_pkg::PH_ADDR: begin
				crc_reg = crc16_next(mrrp_pkg::CRC_INIT, b);
				cnt = 9'd1;
				flen = '0;
				if (b == addr_cfg) begin
					ph = mrrp_pkg::PH_FUNC;
				end else begin
					add_result(mrrp_pkg::KIND_BAD_ADDR, 0, '0, 1'b0);
					ph = mrrp_pkg::PH_DISCARD;
				end
			end
			mrrp_pkg::PH_FUNC: begin
				crc_reg = crc16_next(crc_reg, b);
				fcode = b;
				cnt = 9'd2;
				if (b == mrrp_pkg::FC_WRITE) begin
					flen = mrrp_pkg::LEN_WRITE;
					ph = mrrp_pkg::PH_BODY;
				end else if (b == mrrp_pkg::FC_READ) begin
					ph = mrrp_pkg::PH_COUNT;
				end else begin
					add_result(mrrp_pkg::KIND_BAD_FUNC, 0, '0, 1'b0);
					ph = mrrp_pkg::PH_DISCARD;
				end
			end
			mrrp_pkg::PH_COUNT: begin
				crc_reg = crc16_next(crc_reg, b);
				cnt = 9'd3;
				flen = {1'b0, b} + mrrp_pkg::LEN_OVERHEAD;
				ph = (int'(b) > REG_BYTES) ? mrrp_pkg::PH_SKIP : mrrp_pkg::PH_BODY;
			end
			mrrp_pkg::PH_BODY: begin
				idx = int'(cnt);
				if (idx + 2 < int'(flen)) begin
					crc_reg = crc16_next(crc_reg, b);
					if (fcode == mrrp_pkg::FC_READ && idx >= 3 && idx - 3 < REG_BYTES) begin
						data_store[idx - 3] = b;
					end
					cnt = cnt + 9'd1;
				end else if (idx + 2 == int'(flen)) begin
					held_lo = b;
					cnt = cnt + 9'd1;
				end else begin
					dcount = int'(flen) - int'(mrrp_pkg::LEN_OVERHEAD);
					if (held_lo != crc_reg[7:0] || b != crc_reg[15:8]) begin
						add_result(mrrp_pkg::KIND_CRC_ERR, 0, '0, 1'b0);
					end else if (fcode == mrrp_pkg::FC_WRITE) begin
						add_result(mrrp_pkg::KIND_WRITE_ACK, 0, '0, 1'b0);
					end else if (dcount == REG_BYTES) begin
						for (int w = 0; 2 * w + 1 < REG_BYTES; w++) begin
							add_result(mrrp_pkg::KIND_WORD, w,
								{data_store[2 * w], data_store[2 * w + 1]}, 1'b0);
						end
					end else if (dcount == 2) begin
						add_result(mrrp_pkg::KIND_BLOWER, 0, '0, data_store[1] == 8'd1);
					end else begin
						add_result(mrrp_pkg::KIND_READ_OK, 0, '0, 1'b0);
					end
					ph = mrrp_pkg::PH_ADDR;
					cnt = '0;
				end
			end
			mrrp_pkg::PH_SKIP: begin
				cnt = cnt + 9'd1;
				if (cnt >= flen) begin
					add_result(mrrp_pkg::KIND_TOO_LONG, 0, '0, 1'b0);
					ph = mrrp_pkg::PH_ADDR;
					cnt = '0;
				end
			end
			default: begin
			end
		endcase
		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.last = 1'b1;
			step_results.push_back(r);
		end
	endtask

	// prediction on each byte transfer, comparison on each result transfer
	always @(posedge clk) begin
		mrrp_pkg::result_t want;
		if (byte_valid && byte_ready) begin
			parse_byte(byte_data);
			if (cur_exp == EXP_MODEL) begin
				foreach (step_results[i]) begin
					pending_results.push_back(step_results[i]);
				end
			end else if (cur_exp == EXP_TYPED) begin
				want.kind = cur_kind;
				want.word_index = '0;
				want.word_value = '0;
				want.blower_running = cur_run;
				want.last = 1'b1;
				pending_results.push_back(want);
			end
		end
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: expected no result", $time);
				$display("%0t:   actual kind=%0d index=%0d value=%h run=%b last=%b",
					$time, result.kind, result.word_index, result.word_value,
					result.blower_running, result.last);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result.kind !== want.kind || result.word_index !== want.word_index ||
						result.word_value !== want.word_value ||
						result.blower_running !== want.blower_running ||
						result.last !== want.last) begin
					$display("%0t: expected kind=%0d index=%0d value=%h run=%b last=%b",
						$time, want.kind, want.word_index, want.word_value,
						want.blower_running, want.last);
					$display("%0t:   actual kind=%0d index=%0d value=%h run=%b last=%b",
						$time, result.kind, result.word_index, result.word_value,
						result.blower_running, result.last);
					mismatches++;
				end
			end
		end
	end

	// one byte transfer, with a random gap ahead of it
	task automatic send_byte(input logic [7:0] b, input logic fs);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_data <= '{rx_byte: b, frame_start: fs};
		byte_valid <= 1'b1;
		do @(posedge clk); while (!byte_ready);
		@(negedge clk);
	endtask

	task automatic random_frame();
		logic [7:0]  fr [$];
		logic [7:0]  a;
		logic [15:0] c;
		logic        fs;
		int          sel;
		int          n;
		int          cut;
		bit          junk;
		bit          noise;
		fr = {};
		cut = 0;
		junk = 0;
		noise = 0;
		sel = $urandom_range(0, 99);
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		if (sel < 30 || (sel >= 87 && sel < 91)) begin
			fr = {addr_cfg, mrrp_pkg::FC_READ, 8'(REG_BYTES)};
			repeat (REG_BYTES) fr.push_back(8'($urandom));
		end else if (sel < 45 || (sel >= 91 && sel < 95)) begin
			fr = {addr_cfg, mrrp_pkg::FC_WRITE};
			repeat (4) fr.push_back(8'($urandom));
		end else if (sel < 55) begin
			fr = {addr_cfg, mrrp_pkg::FC_READ, 8'd2, 8'($urandom)};
			fr.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)));
		end else if (sel < 65) begin
			n = $urandom_range(0, REG_BYTES - 1);
			fr = {addr_cfg, mrrp_pkg::FC_READ, 8'(n)};
			repeat (n) fr.push_back(8'($urandom));
		end else if (sel < 73) begin
			n = $urandom_range(REG_BYTES + 1, REG_BYTES + 14);
			fr = {addr_cfg, mrrp_pkg::FC_READ, 8'(n)};
			repeat (n + 2) fr.push_back(8'($urandom));
		end else if (sel < 80) begin
			do a = 8'($urandom); while (a == addr_cfg);
			fr.push_back(a);
			junk = 1;
		end else if (sel < 87) begin
			if ($urandom_range(0, 1) == 0) begin
				a = 8'h80 | (($urandom_range(0, 1) == 0) ? mrrp_pkg::FC_READ
					: mrrp_pkg::FC_WRITE);
			end else begin
				do a = 8'($urandom);
				while (a == mrrp_pkg::FC_READ || a == mrrp_pkg::FC_WRITE);
			end
			fr = {addr_cfg, a};
			junk = 1;
		end else begin
			noise = 1;
			repeat ($urandom_range(1, 6)) fr.push_back(8'($urandom));
		end
		if (sel < 65 || (sel >= 87 && sel < 95)) begin
			c = mrrp_pkg::CRC_INIT;
			foreach (fr[i]) c = crc16_next(c, fr[i]);
			fr.push_back(c[7:0]);
			fr.push_back(c[15:8]);
			// payload or crc hit: the length stays, the crc fails
			if (sel < 65 && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(3, fr.size() - 1);
				fr[n] = fr[n] ^ 8'(1 << $urandom_range(0, 7));
			end
			if (sel >= 87) begin
				cut = $urandom_range(1, fr.size() - 1);
			end
		end
		n = (cut > 0) ? cut : fr.size();
		for (int k = 0; k < n; k++) begin
			if (noise) begin
				fs = 1'($urandom_range(0, 1));
			end else begin
				fs = (k == 0) && (need_start || $urandom_range(0, 2) != 0);
			end
			send_byte(fr[k], fs);
		end
		frame_items += n;
		if (junk) begin
			repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
		end
		need_start = junk || noise || (cut > 0);
	endtask

	task automatic settle();
		byte_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_slave_address(input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * int'(mrrp_pkg::REG_SLAVE_ADDR));
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		addr_cfg = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_frames(input int target);
		frame_items = 0;
		while (frame_items < target) random_frame();
	endtask

	initial begin
		logic [7:0] b;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			cur_exp = plan[i].exp;
			cur_kind = plan[i].kind;
			cur_run = plan[i].run;
			for (int k = 0; k < int'(plan[i].rep); k++) begin
				case (plan[i].src)
					BYTE_RAND:       b = 8'($urandom);
					BYTE_CRC_LO:     b = crc_reg[7:0];
					BYTE_CRC_HI:     b = crc_reg[15:8];
					BYTE_CRC_HI_BAD: b = ~crc_reg[15:8];
					default:         b = plan[i].data;
				endcase
				send_byte(b, plan[i].fs);
			end
		end
		cur_exp = EXP_MODEL;
		need_start = 1;

		run_frames(12);
		settle();
		write_slave_address(8'h00);
		run_frames(4);
		settle();
		write_slave_address(8'hFF);
		run_frames(4);
		settle();
		write_slave_address(8'($urandom_range(2, 254)));
		run_frames(4);

		byte_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// receiver: random stall ahead of every result transfer
	initial begin
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
